### hw/rtl/fdmd_pkg.sv
// Shared types and constants of the frame difference motion detector.
`default_nettype none

package fdmd_pkg;

  localparam int MAX_PIXELS_DEFAULT = 32768;
  localparam int SUM_QUEUE_DEPTH = 4;

  localparam logic [7:0]  DIFF_THRESH_RESET     = 8'd25;
  localparam logic [15:0] MOTION_FRACTION_RESET = 16'd3277;
  localparam logic [31:0] WARMUP_TICKS_RESET    = 32'd3000;
  localparam logic [31:0] HOLDOFF_TICKS_RESET   = 32'd60000;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_TICK  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    REG_DIFF_THRESH     = 2'd0,
    REG_MOTION_FRACTION = 2'd1,
    REG_WARMUP_TICKS    = 2'd2,
    REG_HOLDOFF_TICKS   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] pixel;
    logic       last_pixel;
  } in_item_t;

  typedef struct packed {
    logic        compared;
    logic [15:0] changed_count;
    logic        motion;
    logic        alert;
  } out_item_t;

endpackage

`default_nettype wire

### hw/rtl/fdmd_ram.sv
// Generic simple dual-port RAM, read-first, registered read.
`default_nettype none

module fdmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/fdmd_fifo.sv
// Small register FIFO carrying frame summaries from front to back.
`default_nettype none

module fdmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;
  logic [CNTW-1:0]  count;

  assign dout  = mem[rd_ptr];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fdmd_front.sv
// Front end: takes items, keeps time and frame position, diffs pixels, tallies frames.
`default_nettype none

module fdmd_front import fdmd_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEFAULT,
  localparam int PW = $clog2(MAX_PIXELS + 1),
  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
  localparam int SW = 1 + 2 * PW + 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire in_item_t      item,
  input  wire logic [7:0]    diff_thresh,
  output logic               sum_push,
  output logic      [SW-1:0] sum_data
);

  logic [PW-1:0] pos;
  logic [PW-1:0] ref_len;
  logic [31:0]   elapsed;
  logic [PW-1:0] tally;

  logic          s1_valid;
  logic          s1_cmp;
  logic          s1_last;
  logic          s1_compared;
  logic [7:0]    s1_pix;
  logic [PW-1:0] s1_len;
  logic [31:0]   s1_elapsed;

  logic          is_pix;
  logic          in_range;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] frame_len;
  logic [7:0]    old_pix;
  logic [7:0]    diff;
  logic          hit;
  logic [PW-1:0] tally_next;

  assign is_pix    = accept && (item.mode == MODE_PIXEL);
  assign in_range  = pos < PW'(MAX_PIXELS);
  assign pos_inc   = pos + 1'b1;
  assign frame_len = in_range ? pos_inc : pos;

  fdmd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PIXELS)
  ) u_ref_frame (
    .clk  (clk),
    .we   (is_pix && in_range),
    .waddr(pos[AW-1:0]),
    .wdata(item.pixel),
    .raddr(pos[AW-1:0]),
    .rdata(old_pix)
  );

  assign diff       = (s1_pix > old_pix) ? s1_pix - old_pix : old_pix - s1_pix;
  assign hit        = s1_cmp && (diff > diff_thresh);
  assign tally_next = tally + PW'(hit);

  assign sum_push = s1_valid && s1_last;
  assign sum_data = {s1_compared, tally_next, s1_len, s1_elapsed};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      ref_len  <= '0;
      elapsed  <= '0;
      tally    <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= is_pix;
      if (accept && (item.mode == MODE_TICK)) begin
        elapsed <= elapsed + 1'b1;
      end
      if (is_pix) begin
        if (item.last_pixel) begin
          pos     <= '0;
          ref_len <= frame_len;
        end else begin
          pos <= frame_len;
        end
      end
      if (s1_valid) begin
        tally <= s1_last ? '0 : tally_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_pix) begin
      s1_pix      <= item.pixel;
      s1_cmp      <= in_range && (pos < ref_len);
      s1_last     <= item.last_pixel;
      s1_compared <= (ref_len != '0) && (frame_len == ref_len);
      s1_len      <= frame_len;
      s1_elapsed  <= elapsed;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fdmd_back.sv
// Back end: motion threshold, warm-up and cool-down gating, result register.
`default_nettype none

module fdmd_back import fdmd_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEFAULT,
  localparam int PW = $clog2(MAX_PIXELS + 1),
  localparam int SW = 1 + 2 * PW + 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          sum_empty,
  input  wire logic [SW-1:0] sum_data,
  output logic               sum_pop,
  input  wire logic [15:0]   motion_fraction_q16,
  input  wire logic [31:0]   warmup_ticks,
  input  wire logic [31:0]   holdoff_ticks,
  output out_item_t          result,
  output logic               empty,
  input  wire logic          pop
);

  logic          q_compared;
  logic [PW-1:0] q_tally;
  logic [PW-1:0] q_len;
  logic [31:0]   q_elapsed;

  logic           a_valid;
  logic           a_compared;
  logic [PW-1:0]  a_tally;
  logic [31:0]    a_elapsed;
  logic [PW+15:0] a_rhs;

  logic        b_valid;
  logic [31:0] last_alert;

  logic a_ready;
  logic b_ready;
  logic motion;
  logic alert;

  assign {q_compared, q_tally, q_len, q_elapsed} = sum_data;

  assign b_ready = !b_valid || pop;
  assign a_ready = !a_valid || b_ready;
  assign sum_pop = !sum_empty && a_ready;
  assign empty   = !b_valid;

  assign motion = a_compared && ({a_tally, 16'h0000} > a_rhs);
  assign alert  = motion && (a_elapsed > warmup_ticks) &&
                  ((a_elapsed - last_alert) > holdoff_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      last_alert <= '0;
    end else begin
      if (a_ready) begin
        a_valid <= !sum_empty;
      end
      if (b_ready) begin
        b_valid <= a_valid;
        if (a_valid && alert) begin
          last_alert <= a_elapsed;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_pop) begin
      a_compared <= q_compared;
      a_tally    <= q_tally;
      a_elapsed  <= q_elapsed;
      a_rhs      <= (PW+16)'(q_len) * (PW+16)'(motion_fraction_q16);
    end
    if (b_ready && a_valid) begin
      result.compared      <= a_compared;
      result.changed_count <= a_compared ? 16'(a_tally) : 16'h0000;
      result.motion        <= motion;
      result.alert         <= alert;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/frame_difference_motion_detector.sv
// Top level of the frame difference motion detector: config registers, front, queue, back.
//
//  channel   direction  handshake            payload
//  item      in         push / full          in_item_t  (mode, pixel, last_pixel)
//  result    out        pop / empty          out_item_t (compared, changed_count, motion, alert)
//  config    in         psel/penable/pwrite  4 regs at 0x0, 0x4, 0x8, 0xC
//
// One item per cycle in while full is low. A result passes the front stage register,
// the queue write, the threshold multiply and the result register on its way out.
// full rises only when SUM_QUEUE_DEPTH frame results are queued or in flight.
// Synchronous reset; the reference frame RAM is not cleared.
`default_nettype none

module frame_difference_motion_detector import fdmd_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    item,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int PW   = $clog2(MAX_PIXELS + 1);
  localparam int SW   = 1 + 2 * PW + 32;
  localparam int CRW  = $clog2(SUM_QUEUE_DEPTH + 1);

  logic [7:0]  diff_thresh;
  logic [15:0] motion_fraction_q16;
  logic [31:0] warmup_ticks;
  logic [31:0] holdoff_ticks;

  logic          accept;
  logic          sum_push;
  logic [SW-1:0] sum_wdata;
  logic [SW-1:0] sum_rdata;
  logic          sum_pop;
  logic          sum_empty;
  logic [CRW-1:0] credits_used;
  logic          frame_end;

  assign pready    = 1'b1;
  assign accept    = push && !full;
  assign frame_end = accept && (item.mode == MODE_PIXEL) && item.last_pixel;
  assign full      = (credits_used == CRW'(SUM_QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      credits_used <= '0;
    end else if (frame_end && !sum_pop) begin
      credits_used <= credits_used + 1'b1;
    end else if (sum_pop && !frame_end) begin
      credits_used <= credits_used - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_thresh         <= DIFF_THRESH_RESET;
      motion_fraction_q16 <= MOTION_FRACTION_RESET;
      warmup_ticks        <= WARMUP_TICKS_RESET;
      holdoff_ticks       <= HOLDOFF_TICKS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_DIFF_THRESH:     diff_thresh         <= pwdata[7:0];
        REG_MOTION_FRACTION: motion_fraction_q16 <= pwdata[15:0];
        REG_WARMUP_TICKS:    warmup_ticks        <= pwdata;
        REG_HOLDOFF_TICKS:   holdoff_ticks       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_DIFF_THRESH:     prdata = {24'h0, diff_thresh};
      REG_MOTION_FRACTION: prdata = {16'h0, motion_fraction_q16};
      REG_WARMUP_TICKS:    prdata = warmup_ticks;
      REG_HOLDOFF_TICKS:   prdata = holdoff_ticks;
      default:             prdata = '0;
    endcase
  end

  fdmd_front #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .diff_thresh(diff_thresh),
    .sum_push   (sum_push),
    .sum_data   (sum_wdata)
  );

  fdmd_fifo #(
    .WIDTH(SW),
    .DEPTH(SUM_QUEUE_DEPTH)
  ) u_sum_queue (
    .clk  (clk),
    .rst  (rst),
    .push (sum_push),
    .din  (sum_wdata),
    .pop  (sum_pop),
    .dout (sum_rdata),
    .empty(sum_empty)
  );

  fdmd_back #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .sum_empty          (sum_empty),
    .sum_data           (sum_rdata),
    .sum_pop            (sum_pop),
    .motion_fraction_q16(motion_fraction_q16),
    .warmup_ticks       (warmup_ticks),
    .holdoff_ticks      (holdoff_ticks),
    .result             (result),
    .empty              (empty),
    .pop                (pop)
  );

endmodule

`default_nettype wire

### hw/rtl/fdmd_checker.sv
// Port-level checks on the motion detector, bound to the top level.
`default_nettype none

module fdmd_checker import fdmd_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      full,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t result
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queue not idle after reset");

  a_alert_needs_motion: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.alert) |-> result.motion)
    else $error("alert without motion");

  a_uncompared_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.compared) |-> ((result.changed_count == 16'h0000) && !result.motion))
    else $error("uncompared frame reports a count or motion");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed before transfer");

endmodule

bind frame_difference_motion_detector fdmd_checker u_checker (.*);

`default_nettype wire

### tb/tb_frame_difference_motion_detector.sv
// Self-checking testbench for the frame difference motion detector.
`timescale 1ns / 1ps

module tb_frame_difference_motion_detector;
  import fdmd_pkg::*;

  localparam int FRAME_MAX = MAX_PIXELS_DEFAULT;
  localparam int SCENE_W = 48;

  // Tracks reference frame, timers and registers; queues the verdict due per frame.
  class frame_verdict_board;
    bit [7:0] delta;
    bit [15:0] fraction;
    bit [31:0] warmup;
    bit [31:0] cooldown;
    bit [7:0] last_frame [FRAME_MAX];
    int unsigned ref_len;
    int unsigned pos;
    int unsigned tally;
    bit [31:0] now_ms;
    bit [31:0] alert_ms;
    out_item_t verdicts_due [$];
    int errors;
    int frames;
    int compares;
    int motions;
    int alerts;

    function new();
      delta = DIFF_THRESH_RESET;
      fraction = MOTION_FRACTION_RESET;
      warmup = WARMUP_TICKS_RESET;
      cooldown = HOLDOFF_TICKS_RESET;
    endfunction

    function void set_reg(reg_idx_t idx, bit [31:0] v);
      case (idx)
        REG_DIFF_THRESH: delta = v[7:0];
        REG_MOTION_FRACTION: fraction = v[15:0];
        REG_WARMUP_TICKS: warmup = v;
        REG_HOLDOFF_TICKS: cooldown = v;
        default: ;
      endcase
    endfunction

    function void take_item(in_item_t it);
      bit [7:0] d;
      bit [63:0] lhs;
      bit [63:0] rhs;
      bit [31:0] since;
      out_item_t v;
      if (it.mode == MODE_TICK) begin
        now_ms++;
        return;
      end
      if (pos < FRAME_MAX) begin
        if (pos < ref_len) begin
          d = (it.pixel > last_frame[pos]) ? it.pixel - last_frame[pos]
                                           : last_frame[pos] - it.pixel;
          if (d > delta) tally++;
        end
        last_frame[pos] = it.pixel;
        pos++;
      end
      if (!it.last_pixel) return;
      v = '0;
      v.compared = (ref_len != 0) && (pos == ref_len);
      if (v.compared) begin
        lhs = 64'(tally) << 16;
        rhs = 64'(pos) * 64'(fraction);
        v.changed_count = tally[15:0];
        v.motion = lhs > rhs;
      end
      since = now_ms - alert_ms;
      if (v.motion && now_ms > warmup && since > cooldown) begin
        v.alert = 1'b1;
        alert_ms = now_ms;
      end
      verdicts_due.push_back(v);
      ref_len = pos;
      pos = 0;
      tally = 0;
    endfunction

    function void cmp(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(out_item_t got);
      out_item_t e;
      if (verdicts_due.size() == 0) begin
        $error("result transfer with no frame verdict pending");
        errors++;
        return;
      end
      e = verdicts_due.pop_front();
      frames++;
      compares += e.compared;
      motions += e.motion;
      alerts += e.alert;
      cmp("compared", 16'(e.compared), 16'(got.compared));
      cmp("changed_count", e.changed_count, got.changed_count);
      cmp("motion", 16'(e.motion), 16'(got.motion));
      cmp("alert", 16'(e.alert), 16'(got.alert));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  in_item_t item = '0;
  logic full;
  logic empty;
  logic pready;
  logic [31:0] prdata;
  out_item_t result;

  frame_verdict_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int items_sent = 0;
  int settings = 0;
  bit [7:0] scene [SCENE_W];

  frame_difference_motion_detector uut (.*);

  always #4 clk = ~clk;

  initial begin
    #8_000_000;
    $display("[frame_difference_motion_detector] ERROR");
    $finish;
  end

  initial begin
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (pop && !empty) board.check_verdict(result);
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    board.take_item(it);
    items_sent++;
  endtask

  task automatic send_pixel(bit [7:0] v, bit last);
    in_item_t it;
    it.mode = MODE_PIXEL;
    it.pixel = v;
    it.last_pixel = last;
    send_item(it);
  endtask

  task automatic send_tick(bit last);
    in_item_t it;
    it.mode = MODE_TICK;
    it.pixel = 8'($urandom);
    it.last_pixel = last;
    send_item(it);
  endtask

  // Pixels drift around a remembered scene; change_pct of them jump to random values.
  task automatic send_frame(int len, int change_pct, int tick_pct);
    bit [7:0] v;
    int j;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < tick_pct) repeat ($urandom_range(1, 3)) send_tick(1'($urandom));
      if ($urandom_range(99) < change_pct) begin
        v = 8'($urandom);
      end else begin
        j = int'(scene[i]) + int'($urandom_range(6)) - 3;
        v = (j < 0) ? 8'd0 : (j > 255) ? 8'd255 : j[7:0];
      end
      scene[i] = v;
      send_pixel(v, i == len - 1);
    end
  endtask

  task automatic run_random(int target);
    int len;
    int change;
    len = $urandom_range(1, SCENE_W);
    while (items_sent < target) begin
      if ($urandom_range(99) < 20)
        len = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, SCENE_W);
      if ($urandom_range(99) < 8) repeat ($urandom_range(20, 80)) send_tick(1'($urandom));
      case ($urandom_range(3))
        0: change = 0;
        1: change = 5;
        2: change = 30;
        default: change = 100;
      endcase
      send_frame(len, change, 10);
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    while (board.verdicts_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, bit [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    board.set_reg(idx, v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== v) begin
      $error("prdata of %s: expected %0d, got %0d", idx.name(), v, prdata);
      board.errors++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(bit [7:0] d, bit [15:0] f, bit [31:0] w, bit [31:0] c);
    write_reg(REG_DIFF_THRESH, 32'(d));
    write_reg(REG_MOTION_FRACTION, 32'(f));
    write_reg(REG_WARMUP_TICKS, w);
    write_reg(REG_HOLDOFF_TICKS, c);
    settings++;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    foreach (scene[i]) scene[i] = 8'($urandom);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: no reference yet, length change, delta boundary
    send_tick(1'b1);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd25, 1'b0);
    send_pixel(8'd230, 1'b1);
    send_pixel(8'd51, 1'b0);
    send_pixel(8'd229, 1'b1);
    send_tick(1'b0);
    settle();

    // zero thresholds: alerts and cool-down gating
    set_config(8'd0, 16'd0, 32'd0, 32'd0);
    send_pixel(8'd51, 1'b0);
    send_pixel(8'd229, 1'b1);
    send_pixel(8'd52, 1'b0);
    send_pixel(8'd229, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b1);
    send_tick(1'b0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd0, 1'b1);
    settle();

    set_config(8'd255, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_idling(0, 0);
    run_random(items_sent + 260);
    hold_cycles = 400;
    repeat (30) send_frame(1, 50, 0);
    settle();

    set_config(8'($urandom_range(5, 40)), 16'($urandom_range(1000, 20000)), 32'd10, 32'd15);
    set_idling(59, 0);
    run_random(items_sent + 260);
    settle();

    set_config(8'($urandom), 16'($urandom), $urandom_range(60), $urandom_range(60));
    set_idling(0, 59);
    run_random(items_sent + 260);
    settle();

    set_config(8'd25, 16'd3277, 32'd0, 32'd5);
    set_idling(27, 27);
    run_random(items_sent + 260);
    settle();

    set_config(8'd0, 16'd0, 32'd0, 32'd0);
    set_idling(0, 0);
    run_random(items_sent + 260);
    settle();

    $display("Run covered %0d input transfers and %0d frame verdicts over %0d settings:",
             items_sent, board.frames, settings);
    $display("  %0d compared, %0d with motion, %0d alerts, %0d mismatches.",
             board.compares, board.motions, board.alerts, board.errors);
    if (board.errors == 0 && board.verdicts_due.size() == 0) begin
      $display("[frame_difference_motion_detector] OK");
    end else begin
      $display("[frame_difference_motion_detector] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/fdmd_pkg.sv
hw/rtl/fdmd_ram.sv
hw/rtl/fdmd_fifo.sv
hw/rtl/fdmd_front.sv
hw/rtl/fdmd_back.sv
hw/rtl/frame_difference_motion_detector.sv
hw/rtl/fdmd_checker.sv
tb/tb_frame_difference_motion_detector.sv
